// ----- rtl/core/pdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types and constants shared by the packet deframer core, its controller,
// its datapath and its checker.
// ----------------------------------------------------------------------------
package pdsc_pkg;

    // Frame constants
    localparam logic [7:0]  START_MARK     = 8'hAA;
    localparam int          RESULT_CAP     = 64;
    localparam int          LEN_W          = 7;
    localparam int          TICK_W         = 16;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  SIZE_LIMIT_RST = 7'd64;
    localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd100;

    // Register select (paddr bit 2)
    localparam logic CFG_SIZE_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Input item
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    // Output item
    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             last;
        logic [LEN_W-1:0] packet_length;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_frame;
        logic load_len;
        logic store_byte;
        logic count_tick;
        logic emit_start;
        logic emit_run;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic item_tick;
        logic item_start;
        logic len_ok;
        logic data_done;
        logic sum_ok;
        logic tick_expire;
        logic emit_done;
    } dp_status_t;

endpackage

// ----- rtl/core/pdsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdsc_ctrl
// Frame state machine: walks hunt, length, payload and checksum phases and
// runs the emission burst of a verified packet.
// ----------------------------------------------------------------------------
module pdsc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pdsc_pkg::dp_status_t  status,
    output pdsc_pkg::ctrl_cmd_t   cmd
);

    pdsc_pkg::state_t state_reg;
    pdsc_pkg::state_t state_next;
    logic             accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdsc_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input is held off only while a packet is streamed out
    assign in_stall = (state_reg == pdsc_pkg::ST_EMIT);
    assign accept   = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            pdsc_pkg::ST_HUNT:
            begin
                if (accept && !status.item_tick && status.item_start)
                begin
                    state_next = pdsc_pkg::ST_LEN;
                end
            end
            pdsc_pkg::ST_LEN:
            begin
                if (accept && !status.item_tick)
                begin
                    if (status.len_ok)
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = pdsc_pkg::ST_DATA;
                    end
                    else
                    begin
                        cmd.clear_frame = 1'b1;
                        state_next      = pdsc_pkg::ST_HUNT;
                    end
                end
            end
            pdsc_pkg::ST_DATA:
            begin
                if (accept)
                begin
                    if (status.item_tick)
                    begin
                        if (status.tick_expire)
                        begin
                            cmd.clear_frame = 1'b1;
                            state_next      = pdsc_pkg::ST_HUNT;
                        end
                        else
                        begin
                            cmd.count_tick = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                        if (status.data_done)
                        begin
                            state_next = pdsc_pkg::ST_SUM;
                        end
                    end
                end
            end
            pdsc_pkg::ST_SUM:
            begin
                if (accept)
                begin
                    if (status.item_tick)
                    begin
                        if (status.tick_expire)
                        begin
                            cmd.clear_frame = 1'b1;
                            state_next      = pdsc_pkg::ST_HUNT;
                        end
                        else
                        begin
                            cmd.count_tick = 1'b1;
                        end
                    end
                    else if (status.sum_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = pdsc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cmd.clear_frame = 1'b1;
                        state_next      = pdsc_pkg::ST_HUNT;
                    end
                end
            end
            pdsc_pkg::ST_EMIT:
            begin
                cmd.emit_run = 1'b1;
                if (status.emit_done)
                begin
                    cmd.clear_frame = 1'b1;
                    state_next      = pdsc_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = pdsc_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

// ----- rtl/core/pdsc_dpath.sv -----
// ----------------------------------------------------------------------------
// pdsc_dpath
// Frame counters, running sum, tick timer, payload buffer and the output
// stage that streams a verified packet out one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pdsc_dpath #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pdsc_pkg::in_item_t                    in_item,
    input  logic [pdsc_pkg::LEN_W-1:0]            size_limit,
    input  logic [pdsc_pkg::TICK_W-1:0]           timeout_ticks,
    input  pdsc_pkg::ctrl_cmd_t                   cmd,
    output pdsc_pkg::dp_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pdsc_pkg::out_item_t                   out_item
);

    // Only the first RESULT_CAP entries can ever be used
    localparam int MEM_DEPTH = (BUFFER_DEPTH < pdsc_pkg::RESULT_CAP) ?
                               BUFFER_DEPTH : pdsc_pkg::RESULT_CAP;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [pdsc_pkg::LEN_W-1:0] LEN_CAP = pdsc_pkg::LEN_W'(MEM_DEPTH);

    logic [pdsc_pkg::LEN_W-1:0]  exp_reg,     exp_next;
    logic [pdsc_pkg::LEN_W-1:0]  cnt_reg,     cnt_next;
    logic [7:0]                  sum_reg,     sum_next;
    logic [pdsc_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [pdsc_pkg::LEN_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic                        rd_vld_reg,  rd_vld_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  rd_data_reg;
    logic                        rd_last_reg;
    pdsc_pkg::out_item_t         out_item_reg;
    logic [7:0]                  store_reg [MEM_DEPTH];

    logic [pdsc_pkg::LEN_W-1:0]  len_lim;
    logic [pdsc_pkg::LEN_W-1:0]  cnt_inc;
    logic [pdsc_pkg::LEN_W-1:0]  rd_ptr_inc;
    logic [pdsc_pkg::TICK_W-1:0] elapsed_inc;
    logic [pdsc_pkg::TICK_W-1:0] tick_lim;
    logic                        store_wr;
    logic                        rd_issue;
    logic                        out_load;

    // Frame checks on the current item
    assign len_lim     = (size_limit < LEN_CAP) ? size_limit : LEN_CAP;
    assign cnt_inc     = cnt_reg + 1'b1;
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign tick_lim    = (timeout_ticks == '0) ? pdsc_pkg::TICK_W'(1) : timeout_ticks;

    always_comb
    begin
        status.item_tick   = (in_item.kind == pdsc_pkg::KIND_TICK);
        status.item_start  = (in_item.rx_byte == pdsc_pkg::START_MARK);
        status.len_ok      = (in_item.rx_byte != 8'd0) &&
                             (in_item.rx_byte <= {1'b0, len_lim});
        status.data_done   = (cnt_inc >= exp_reg);
        status.sum_ok      = (in_item.rx_byte == sum_reg);
        status.tick_expire = (elapsed_inc >= tick_lim);
        // all bytes read and handed to the output register
        status.emit_done   = (rd_ptr_reg == exp_reg) && !rd_vld_reg;
    end

    // Emission pipeline: buffer read, then output register
    assign out_load   = rd_vld_reg && (!out_valid_reg || !out_stall);
    assign rd_issue   = cmd.emit_run && (rd_ptr_reg < exp_reg) && (!rd_vld_reg || out_load);
    assign rd_ptr_inc = rd_ptr_reg + 1'b1;
    assign store_wr   = cmd.store_byte && (cnt_reg < LEN_CAP);

    // Frame counters
    always_comb
    begin
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        elapsed_next = elapsed_reg;
        rd_ptr_next  = rd_ptr_reg;
        priority if (cmd.clear_frame)
        begin
            exp_next     = '0;
            cnt_next     = '0;
            sum_next     = '0;
            elapsed_next = '0;
            rd_ptr_next  = '0;
        end
        else if (cmd.load_len)
        begin
            exp_next     = in_item.rx_byte[pdsc_pkg::LEN_W-1:0];
            cnt_next     = '0;
            sum_next     = '0;
            elapsed_next = '0;
        end
        else if (cmd.store_byte)
        begin
            cnt_next = cnt_inc;
            sum_next = sum_reg + in_item.rx_byte;
        end
        else if (cmd.count_tick)
        begin
            elapsed_next = elapsed_inc;
        end
        else if (cmd.emit_start)
        begin
            rd_ptr_next = '0;
        end
        else if (rd_issue)
        begin
            rd_ptr_next = rd_ptr_inc;
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    // Read stage and output valid
    always_comb
    begin
        rd_vld_next = rd_vld_reg;
        priority if (rd_issue)
        begin
            rd_vld_next = 1'b1;
        end
        else if (out_load)
        begin
            rd_vld_next = 1'b0;
        end
        else
        begin
            rd_vld_next = rd_vld_reg;
        end

        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            elapsed_reg   <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_reg       <= exp_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            elapsed_reg   <= elapsed_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[cnt_reg[AW-1:0]] <= in_item.rx_byte;
        end
        if (rd_issue)
        begin
            rd_data_reg <= store_reg[rd_ptr_reg[AW-1:0]];
            rd_last_reg <= (rd_ptr_inc == exp_reg);
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg.payload_byte  <= rd_data_reg;
            out_item_reg.last          <= rd_last_reg;
            out_item_reg.packet_length <= exp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/core/packet_deframer_sum_check_core.sv -----
// ----------------------------------------------------------------------------
// packet_deframer_sum_check_core
// Receive deframer for start/length/payload/checksum packets with a
// millisecond-tick frame timeout; emits verified payload bytes only.
//
//   channel   dir  handshake             payload
//   in        in   in_valid / in_stall   in_item  (kind, rx_byte)
//   out       out  out_valid / out_stall out_item (payload_byte, last,
//                                                  packet_length)
//   cfg       in   APB psel/penable      size limit @0x0, timeout_ticks @0x4
//
// Each input item is taken in the cycle it is offered while not emitting.
// A matching checksum stalls the input while the packet is emitted: the
// payload buffer's single read port gives one byte per cycle.
// Output stalls hold the output register and slow the burst down to match.
// Reset clears all control state; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
module packet_deframer_sum_check_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pdsc_pkg::in_item_t   in_item,
    // output items
    output logic                 out_valid,
    input  logic                 out_stall,
    output pdsc_pkg::out_item_t  out_item,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [pdsc_pkg::LEN_W-1:0]  size_limit_reg,  size_limit_next;
    logic [pdsc_pkg::TICK_W-1:0] timeout_reg,     timeout_next;
    logic                        cfg_wr;
    pdsc_pkg::ctrl_cmd_t         cmd;
    pdsc_pkg::dp_status_t        status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        size_limit_next = size_limit_reg;
        timeout_next    = timeout_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                pdsc_pkg::CFG_SIZE_LIMIT: size_limit_next = pwdata[pdsc_pkg::LEN_W-1:0];
                pdsc_pkg::CFG_TIMEOUT:    timeout_next    = pwdata[pdsc_pkg::TICK_W-1:0];
                default:                  size_limit_next = size_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= pdsc_pkg::SIZE_LIMIT_RST;
            timeout_reg    <= pdsc_pkg::TIMEOUT_RST;
        end
        else
        begin
            size_limit_reg <= size_limit_next;
            timeout_reg    <= timeout_next;
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            pdsc_pkg::CFG_SIZE_LIMIT: prdata = {25'd0, size_limit_reg};
            pdsc_pkg::CFG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            default:                  prdata = '0;
        endcase
    end

    // Frame controller
    pdsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    pdsc_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_item       (in_item),
        .size_limit    (size_limit_reg),
        .timeout_ticks (timeout_reg),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

endmodule

// ----- rtl/core/pdsc_checker.sv -----
// ----------------------------------------------------------------------------
// pdsc_checker
// Port-level checks on the deframer core, bound to the top level.
// ----------------------------------------------------------------------------
module pdsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input pdsc_pkg::out_item_t out_item,
    input logic                out_valid,
    input logic                out_stall
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed under stall");

    // Every emitted item belongs to a packet of nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.packet_length != '0)
        else $error("emitted item with zero packet length");

    // A burst only starts on an accepted item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stalled without an accepted item");

    // Within a packet the input stays held and the length does not change
    a_burst_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.last |=>
            in_stall && (!out_valid ||
                         out_item.packet_length == $past(out_item.packet_length)))
        else $error("packet burst broken before its last item");

endmodule

bind packet_deframer_sum_check_core pdsc_checker u_pdsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packet deframer core. A behavioral deframer
// tracks start, length, payload, checksum and tick timeout. It queues the
// payload bytes that each verified packet must produce. Directed frames
// cover the corner cases and register extremes. Random frames follow,
// mostly well formed with some broken ones, under several register
// settings, with random idle gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 80;
    localparam int PAYLOAD_SLOTS = 64;
    localparam int ITEMS_PER_SETTING = 5;

    // deframer phase as tracked by the predictor
    typedef enum logic [1:0] {
        HUNTING,
        WANT_LEN,
        IN_PAYLOAD,
        WANT_SUM
    } rx_phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    pdsc_pkg::in_item_t   in_item;
    logic                 out_valid;
    logic                 out_stall;
    pdsc_pkg::out_item_t  out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // predictor state and register shadow
    rx_phase_t            rx_phase;
    logic [6:0]           want_len;
    logic [6:0]           got_count;
    logic [7:0]           byte_sum;
    logic [15:0]          tick_count;
    logic [7:0]           held_bytes [PAYLOAD_SLOTS];
    logic [6:0]           cfg_max_len;
    logic [15:0]          cfg_timeout;
    pdsc_pkg::out_item_t  expected_bytes [$];

    // stimulus scratch and bookkeeping
    logic [7:0]  frame_buf [PAYLOAD_SLOTS];
    bit          gaps_on;
    int          items_sent;
    int          bytes_checked;
    int          packets_sent;
    int          error_count;
    int          cycles;

    packet_deframer_sum_check_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: timed out after %0d cycles", cycles);
        $display("testbench: done, errors");
        $finish;
    end

    // count a failure; only the first few are printed
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------- predictor ----------------

    function automatic int len_ceiling();
        return (cfg_max_len > PAYLOAD_SLOTS) ? PAYLOAD_SLOTS : int'(cfg_max_len);
    endfunction

    function automatic int tick_ceiling();
        return (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
    endfunction

    task automatic restart_hunt();
        rx_phase   = HUNTING;
        want_len   = '0;
        got_count  = '0;
        byte_sum   = '0;
        tick_count = '0;
    endtask

    // advance the deframer by one accepted item, queue any payload it frees
    task automatic deframe_item(input logic kind, input logic [7:0] data);
        pdsc_pkg::out_item_t res;
        if (kind == pdsc_pkg::KIND_TICK)
        begin
            if (rx_phase == IN_PAYLOAD || rx_phase == WANT_SUM)
            begin
                tick_count = tick_count + 16'd1;
                if (int'(tick_count) >= tick_ceiling())
                    restart_hunt();
            end
        end
        else
        begin
            case (rx_phase)
                HUNTING:
                begin
                    if (data == pdsc_pkg::START_MARK)
                        rx_phase = WANT_LEN;
                end
                WANT_LEN:
                begin
                    if (data == 8'd0 || int'(data) > len_ceiling())
                        restart_hunt();
                    else
                    begin
                        want_len   = data[6:0];
                        got_count  = '0;
                        byte_sum   = '0;
                        tick_count = '0;
                        rx_phase   = IN_PAYLOAD;
                    end
                end
                IN_PAYLOAD:
                begin
                    if (got_count < PAYLOAD_SLOTS)
                        held_bytes[got_count] = data;
                    byte_sum  = byte_sum + data;
                    got_count = got_count + 7'd1;
                    if (got_count >= want_len)
                        rx_phase = WANT_SUM;
                end
                default:
                begin
                    // checksum byte: release the packet only on a match
                    if (data == byte_sum)
                    begin
                        for (int i = 0; i < int'(want_len); i++)
                        begin
                            res.payload_byte  = held_bytes[i];
                            res.last          = (i + 1 == int'(want_len));
                            res.packet_length = want_len;
                            expected_bytes.push_back(res);
                        end
                    end
                    restart_hunt();
                end
            endcase
        end
    endtask

    // ---------------- input side ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // drive one item from a falling edge, return at the edge that takes it
    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.kind    = kind;
        in_item.rx_byte = data;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        deframe_item(kind, data);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(pdsc_pkg::KIND_TICK, 8'($urandom));
    endtask

    task automatic fill_payload(input int n);
        for (int i = 0; i < n; i++)
            frame_buf[i] = 8'($urandom);
    endtask

    // start, length, n_data bytes of frame_buf, optional checksum;
    // ticks are scattered over the frame, leftovers go at the end
    task automatic send_frame(input int len_byte, input int n_data, input bit with_sum,
                              input bit bad_sum, input int n_ticks);
        int ticks_left;
        logic [7:0] sum;
        ticks_left = n_ticks;
        sum = '0;
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        send_item(pdsc_pkg::KIND_BYTE, 8'(len_byte));
        for (int i = 0; i < n_data; i++)
        begin
            while (ticks_left > 0 && $urandom_range(0, 3) == 0)
            begin
                send_tick();
                ticks_left--;
            end
            send_item(pdsc_pkg::KIND_BYTE, frame_buf[i]);
            sum = sum + frame_buf[i];
        end
        if (with_sum)
        begin
            while (ticks_left > 0 && $urandom_range(0, 3) == 0)
            begin
                send_tick();
                ticks_left--;
            end
            send_item(pdsc_pkg::KIND_BYTE,
                      bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
        while (ticks_left > 0)
        begin
            send_tick();
            ticks_left--;
        end
        packets_sent++;
    endtask

    // hold the input until every queued byte is out and the core has settled
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------- register port ----------------

    task automatic write_reg(input logic sel, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        wait_idle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == pdsc_pkg::CFG_SIZE_LIMIT)
            cfg_max_len = value[6:0];
        else
            cfg_timeout = value[15:0];
        // read back
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        want = (sel == pdsc_pkg::CFG_SIZE_LIMIT) ? {25'd0, cfg_max_len} :
                                                   {16'd0, cfg_timeout};
        if (rd !== want)
            note_error($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                                 paddr, rd, want));
    endtask

    // ---------------- output side ----------------

    // random stall pattern: clear stretches, choppy stretches, a few long holds
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 19);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                @(negedge clk);
                if (mode < 8)
                    out_stall = 1'b0;
                else if (mode < 19)
                    out_stall = ($urandom_range(0, 2) == 0);
                else
                    out_stall = 1'b1;
            end
        end
    end

    // compare each delivered byte with the oldest queued one
    always @(posedge clk)
    begin
        pdsc_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                note_error($sformatf("unexpected output byte=%02h last=%0b len=%0d",
                                     out_item.payload_byte, out_item.last,
                                     out_item.packet_length));
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (out_item.payload_byte !== want.payload_byte ||
                    out_item.last !== want.last ||
                    out_item.packet_length !== want.packet_length)
                    note_error($sformatf({"output mismatch: byte=%02h last=%0b len=%0d,",
                                          " expected byte=%02h last=%0b len=%0d"},
                                         out_item.payload_byte, out_item.last,
                                         out_item.packet_length, want.payload_byte,
                                         want.last, want.packet_length));
            end
        end
    end

    // ---------------- tests ----------------

    // framing corner cases under the reset register values
    task automatic test_framing_directed();
        gaps_on = 1'b1;
        // noise and ticks while hunting
        send_item(pdsc_pkg::KIND_BYTE, 8'h00);
        send_item(pdsc_pkg::KIND_BYTE, 8'hFF);
        send_tick();
        // tick while waiting for the length is ignored, zero length drops
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        send_tick();
        send_item(pdsc_pkg::KIND_BYTE, 8'h00);
        // one over the default limit
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        send_item(pdsc_pkg::KIND_BYTE, 8'd65);
        // start mark taken as length is far too long
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        // one byte packet, all ones
        frame_buf[0] = 8'hFF;
        send_frame(1, 1, 1'b1, 1'b0, 0);
        // all zero packet with one tick, sent inside or after the frame
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'h00;
        send_frame(2, 2, 1'b1, 1'b0, 1);
        // bad checksum
        frame_buf[0] = 8'h5A;
        frame_buf[1] = 8'hA5;
        frame_buf[2] = 8'h81;
        send_frame(3, 3, 1'b1, 1'b1, 0);
    endtask

    // register extremes: tightest limits, zero values, widest settings
    task automatic test_register_extremes();
        gaps_on = 1'b1;
        write_reg(pdsc_pkg::CFG_SIZE_LIMIT, 32'd1);
        write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd1);
        fill_payload(2);
        send_frame(2, 2, 1'b1, 1'b0, 0);       // over the limit of one
        fill_payload(1);
        send_frame(1, 1, 1'b1, 1'b0, 0);       // exactly at the limit
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);  // first tick times out
        send_item(pdsc_pkg::KIND_BYTE, 8'd1);
        send_tick();
        send_item(pdsc_pkg::KIND_BYTE, 8'h11);
        send_item(pdsc_pkg::KIND_BYTE, 8'h11);

        // zero timeout behaves as one tick
        write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd0);
        send_item(pdsc_pkg::KIND_BYTE, pdsc_pkg::START_MARK);
        send_item(pdsc_pkg::KIND_BYTE, 8'd1);
        send_item(pdsc_pkg::KIND_BYTE, 8'h22);
        send_tick();
        send_item(pdsc_pkg::KIND_BYTE, 8'h22);

        // zero maximum length rejects everything
        write_reg(pdsc_pkg::CFG_SIZE_LIMIT, 32'd0);
        fill_payload(1);
        send_frame(1, 1, 1'b1, 1'b0, 0);

        // full size packet with the widest timeout
        write_reg(pdsc_pkg::CFG_SIZE_LIMIT, 32'd64);
        write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd65535);
        fill_payload(64);
        send_frame(64, 64, 1'b1, 1'b0, 5);

        // timeout of two: one tick survives, the second drops
        write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd2);
        fill_payload(3);
        send_frame(3, 3, 1'b1, 1'b0, 1);
        fill_payload(3);
        send_frame(3, 1, 1'b0, 1'b0, 2);
    endtask

    // random frames under several settings, mostly well formed
    task automatic test_random_traffic();
        int lim;
        int n;
        int r;
        int start_count;
        for (int setting = 0; setting < 4; setting++)
        begin
            case (setting)
                0:
                begin
                    write_reg(pdsc_pkg::CFG_SIZE_LIMIT, 32'd64);
                    write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd65535);
                end
                1:
                begin
                    write_reg(pdsc_pkg::CFG_SIZE_LIMIT, $urandom_range(2, 12));
                    write_reg(pdsc_pkg::CFG_TIMEOUT, $urandom_range(2, 8));
                end
                2:
                begin
                    write_reg(pdsc_pkg::CFG_SIZE_LIMIT, 32'd127);
                    write_reg(pdsc_pkg::CFG_TIMEOUT, 32'd100);
                end
                default:
                begin
                    write_reg(pdsc_pkg::CFG_SIZE_LIMIT, $urandom_range(1, 64));
                    write_reg(pdsc_pkg::CFG_TIMEOUT, $urandom_range(3, 40));
                end
            endcase
            start_count = items_sent;
            while (items_sent - start_count < ITEMS_PER_SETTING)
            begin
                gaps_on = ($urandom_range(0, 4) != 0);
                lim = len_ceiling();
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    // short good packet
                    n = $urandom_range(1, (lim < 8) ? lim : 8);
                    fill_payload(n);
                    send_frame(n, n, 1'b1, 1'b0,
                               $urandom_range(0, (tick_ceiling() > 4) ? 3 : tick_ceiling() - 1));
                end
                else if (r < 65)
                begin
                    // good packet of any allowed size
                    n = $urandom_range(1, lim);
                    fill_payload(n);
                    send_frame(n, n, 1'b1, 1'b0, 0);
                end
                else if (r < 75)
                begin
                    n = $urandom_range(1, lim);
                    fill_payload(n);
                    send_frame(n, n, 1'b1, 1'b1, 0);
                end
                else if (r < 83)
                begin
                    // rejected length followed by stray bytes
                    n = $urandom_range(0, 3);
                    fill_payload(n);
                    send_frame(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(lim + 1, 255),
                               n, 1'b0, 1'b0, 0);
                end
                else if (r < 92)
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(($urandom_range(0, 1) == 0) ? pdsc_pkg::KIND_BYTE :
                                                                pdsc_pkg::KIND_TICK,
                                  ($urandom_range(0, 3) == 0) ? pdsc_pkg::START_MARK :
                                                                8'($urandom));
                end
                else if (tick_ceiling() <= 40)
                begin
                    // frame cut short and left to time out
                    n = $urandom_range(1, lim);
                    fill_payload(n);
                    send_frame(n, $urandom_range(0, n - 1), 1'b0, 1'b0, tick_ceiling());
                end
                else
                begin
                    n = $urandom_range(1, lim);
                    fill_payload(n);
                    send_frame(n, n, 1'b1, 1'b0, 0);
                end
            end
            // let the last burst drain completely once per setting
            wait_idle();
        end
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        gaps_on   = 1'b0;
        items_sent    = 0;
        bytes_checked = 0;
        packets_sent  = 0;
        error_count   = 0;
        cfg_max_len   = pdsc_pkg::SIZE_LIMIT_RST;
        cfg_timeout   = pdsc_pkg::TIMEOUT_RST;
        restart_hunt();
        for (int i = 0; i < PAYLOAD_SLOTS; i++)
        begin
            held_bytes[i] = '0;
            frame_buf[i]  = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_framing_directed();
        test_register_extremes();
        test_random_traffic();

        // drain and watch for stray output
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_bytes.size() != 0)
            note_error($sformatf("%0d payload bytes never delivered", expected_bytes.size()));

        $display("testbench: %0d items sent in %0d frames, %0d payload bytes compared,",
                 items_sent, packets_sent, bytes_checked);
        $display("testbench: register extremes, timeouts and bad frames exercised, %0d errors",
                 error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- packet_deframer_sum_check_core.f -----
rtl/core/pdsc_pkg.sv
rtl/core/pdsc_ctrl.sv
rtl/core/pdsc_dpath.sv
rtl/core/packet_deframer_sum_check_core.sv
rtl/core/pdsc_checker.sv
tb/testbench.sv
